### hdl/sv39ptw_pkg.sv
// types and constants shared by the sv39 page table walker
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps

package sv39ptw_pkg;

    localparam int XLEN         = 64;
    localparam int PPN_W        = 44;
    localparam int IDX_W        = 9;
    localparam int OFF_W        = 12;
    localparam int PERM_W       = 10;
    localparam int ENTRY_ADDR_W = 15;
    localparam int CFG_IDX_W    = 2;
    localparam int PTE_PPN_LSB  = 10;
    // slots reachable through the 15-bit entry address
    localparam int MAX_STORE_PAGES = 2 ** (ENTRY_ADDR_W - IDX_W);

    localparam logic KIND_WRITE     = 1'b0;
    localparam logic KIND_TRANSLATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PPN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_OFFSET = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REPLY,
        ST_WALK_L2,
        ST_WALK_L1,
        ST_WALK_L0
    } walk_state_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_ROOT_INVALID = 2'd1,
        STATUS_L1_INVALID   = 2'd2,
        STATUS_OUTSIDE      = 2'd3
    } walk_status_t;

    typedef enum logic [1:0] {
        LVL_ROOT,
        LVL_1,
        LVL_0
    } walk_level_t;

    typedef struct packed {
        logic         clr_en;
        logic         latch;
        logic         wr_en;
        logic         rd_en;
        walk_level_t  lvl;
        logic         load_out;
        logic         leaf_sel;
        walk_status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic loc_in_store;
        logic entry_valid;
    } dp_stat_t;

endpackage

### hdl/sv39_page_table_walk.sv
// sv39 page table walker top level: controller plus datapath
// depends on sv39ptw_pkg, sv39ptw_ctrl and sv39ptw_dp
//
// usage
//   cfg channel: one beat writes a register (0 root ppn, 1 store base ppn,
//   2 result offset); always ready, write only while the walker is idle.
//   in channel: one beat per item; kind 0 stores entry_value at
//   entry_address (slot*512 + index), kind 1 translates virt_addr.
//   out channel: one beat per item with status, out_addr and perm_bits.
// walk
//   a translation makes three dependent reads of the single-port store, for the
//   root, level-1 and level-0 entries, each with registered read data; faults
//   end the walk early. the result sits in an output register, so a stalled
//   receiver holds the walker only when the next result is ready to be loaded.
// reset
//   after reset the store is zeroed one entry per cycle, min(TABLE_PAGES,64)
//   * 512 entries in all (32768 at the default); in_ready stays low meanwhile,
//   the cfg channel keeps taking writes.
`timescale 1ns / 1ps

module sv39_page_table_walk #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sv39ptw_pkg::XLEN-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [sv39ptw_pkg::XLEN-1:0]          virt_addr,
    input  logic [sv39ptw_pkg::ENTRY_ADDR_W-1:0]  entry_address,
    input  logic [sv39ptw_pkg::XLEN-1:0]          entry_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            status,
    output logic [sv39ptw_pkg::XLEN-1:0]          out_addr,
    output logic [sv39ptw_pkg::PERM_W-1:0]        perm_bits
);
    import sv39ptw_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sv39ptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sv39ptw_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .virt_addr     (virt_addr),
        .entry_address (entry_address),
        .entry_value   (entry_value),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .out_addr      (out_addr),
        .perm_bits     (perm_bits)
    );

endmodule

### hdl/sv39ptw_ctrl.sv
// walk controller: state machine sequencing store clear, entry writes and the
// three-level walk; depends on sv39ptw_pkg
`timescale 1ns / 1ps

module sv39ptw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    output logic               out_valid,
    input  logic               out_ready,
    input  sv39ptw_pkg::dp_stat_t stat,
    output sv39ptw_pkg::dp_cmd_t  cmd
);
    import sv39ptw_pkg::*;

    walk_state_t  state_reg;
    walk_state_t  state_next;
    walk_status_t pend_status_reg;
    walk_status_t pend_status_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            pend_status_reg <= STATUS_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_WRITE)
                    begin
                        pend_status_next = STATUS_OK;
                        state_next       = ST_REPLY;
                    end
                    else if (stat.loc_in_store)
                        state_next = ST_WALK_L2;
                    else
                    begin
                        pend_status_next = STATUS_OUTSIDE;
                        state_next       = ST_REPLY;
                    end
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK_L2:
            begin
                if (stat.entry_valid && stat.loc_in_store)
                    state_next = ST_WALK_L1;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK_L1:
            begin
                if (stat.entry_valid && stat.loc_in_store)
                    state_next = ST_WALK_L0;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK_L0:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.lvl = LVL_ROOT;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (kind == KIND_WRITE)
                        cmd.wr_en = 1'b1;
                    else
                        cmd.rd_en = stat.loc_in_store;
                end
            end
            ST_REPLY:
            begin
                cmd.load_out   = out_free;
                cmd.out_status = pend_status_reg;
            end
            ST_WALK_L2:
            begin
                cmd.lvl = LVL_1;
                if (!stat.entry_valid)
                begin
                    cmd.load_out   = out_free;
                    cmd.out_status = STATUS_ROOT_INVALID;
                end
                else if (!stat.loc_in_store)
                begin
                    cmd.load_out   = out_free;
                    cmd.out_status = STATUS_OUTSIDE;
                end
                else
                    cmd.rd_en = 1'b1;
            end
            ST_WALK_L1:
            begin
                cmd.lvl = LVL_0;
                if (!stat.entry_valid)
                begin
                    cmd.load_out   = out_free;
                    cmd.out_status = STATUS_L1_INVALID;
                end
                else if (!stat.loc_in_store)
                begin
                    cmd.load_out   = out_free;
                    cmd.out_status = STATUS_OUTSIDE;
                end
                else
                    cmd.rd_en = 1'b1;
            end
            ST_WALK_L0:
            begin
                cmd.load_out   = out_free;
                cmd.leaf_sel   = 1'b1;
                cmd.out_status = STATUS_OK;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

`ifndef SYNTHESIS
    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

    // single store port: never a write and a read in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.wr_en || cmd.clr_en) && cmd.rd_en))
        else $error("store write and read in the same cycle");

    // every store read is consumed by a walk state
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> (state_reg == ST_WALK_L2 || state_reg == ST_WALK_L1
                       || state_reg == ST_WALK_L0))
        else $error("store read issued outside the walk");

    // clearing happens once, after reset only
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("store clear re-entered");
`endif

endmodule

### hdl/sv39ptw_dp.sv
// walk datapath: configuration registers, page table store, page location
// check and result register; depends on sv39ptw_pkg
`timescale 1ns / 1ps

module sv39ptw_dp #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sv39ptw_pkg::XLEN-1:0]               cfg_data,
    input  logic [sv39ptw_pkg::XLEN-1:0]               virt_addr,
    input  logic [sv39ptw_pkg::ENTRY_ADDR_W-1:0]       entry_address,
    input  logic [sv39ptw_pkg::XLEN-1:0]               entry_value,
    input  sv39ptw_pkg::dp_cmd_t                       cmd,
    output sv39ptw_pkg::dp_stat_t                      stat,
    output logic [1:0]                                 status,
    output logic [sv39ptw_pkg::XLEN-1:0]               out_addr,
    output logic [sv39ptw_pkg::PERM_W-1:0]             perm_bits
);
    import sv39ptw_pkg::*;

    // slots beyond the write address range are never written and read as zero
    localparam int STORE_PAGES = (TABLE_PAGES < MAX_STORE_PAGES) ? TABLE_PAGES
                                                                 : MAX_STORE_PAGES;
    localparam int SW    = $clog2(STORE_PAGES);
    localparam int AW    = SW + IDX_W;
    localparam int DEPTH = STORE_PAGES * (2 ** IDX_W);
    localparam int VA_W  = 2 * IDX_W + OFF_W;

    logic [PPN_W-1:0]  root_ppn_reg;
    logic [PPN_W-1:0]  store_base_reg;
    logic [XLEN-1:0]   result_offset_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [VA_W-1:0]   va_reg;
    logic [XLEN-1:0]   rd_data_reg;
    logic              rd_zero_reg;
    logic [1:0]        status_reg;
    logic [XLEN-1:0]   out_addr_reg;
    logic [PERM_W-1:0] perm_reg;

    logic [XLEN-1:0]   mem [DEPTH];

    logic [XLEN-1:0]   entry_seen;
    logic [PPN_W-1:0]  entry_ppn;
    logic [PPN_W-1:0]  loc_ppn;
    logic [PPN_W:0]    loc_diff;
    logic              loc_in_store;
    logic              loc_in_mem;
    logic [IDX_W-1:0]  rd_idx;
    logic [SW-1:0]     wr_slot;
    logic              wr_in_range;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [XLEN-1:0]   mem_wdata;
    logic [XLEN-1:0]   leaf_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg      <= '0;
            store_base_reg    <= '0;
            result_offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROOT_PPN:      root_ppn_reg      <= cfg_data[PPN_W-1:0];
                CFG_STORE_BASE:    store_base_reg    <= cfg_data[PPN_W-1:0];
                CFG_RESULT_OFFSET: result_offset_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_en)
            clr_addr_reg <= clr_addr_reg + AW'(1);
    end

    assign stat.clr_last = (clr_addr_reg == AW'(DEPTH - 1));

    // entry as seen by the walk: slots past the physical store read as zero
    assign entry_seen = rd_zero_reg ? '0 : rd_data_reg;
    assign entry_ppn  = entry_seen[PTE_PPN_LSB +: PPN_W];
    assign stat.entry_valid = entry_seen[0];

    // page location: one subtract and two compares against the store window
    assign loc_ppn      = (cmd.lvl == LVL_ROOT) ? root_ppn_reg : entry_ppn;
    assign loc_diff     = {1'b0, loc_ppn} - {1'b0, store_base_reg};
    assign loc_in_store = !loc_diff[PPN_W] && (loc_diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
    assign loc_in_mem   = !loc_diff[PPN_W] && (loc_diff[PPN_W-1:0] < PPN_W'(STORE_PAGES));
    assign stat.loc_in_store = loc_in_store;

    always_comb
    begin
        unique case (cmd.lvl)
            LVL_ROOT: rd_idx = virt_addr[OFF_W + 2*IDX_W +: IDX_W];
            LVL_1:    rd_idx = va_reg[OFF_W + IDX_W +: IDX_W];
            LVL_0:    rd_idx = va_reg[OFF_W +: IDX_W];
            default:  rd_idx = '0;
        endcase
    end

    assign wr_slot     = entry_address[IDX_W +: SW];
    assign wr_in_range = ({1'b0, entry_address[ENTRY_ADDR_W-1:IDX_W]}
                          < (ENTRY_ADDR_W - IDX_W + 1)'(STORE_PAGES));
    assign mem_we      = cmd.clr_en || (cmd.wr_en && wr_in_range);
    assign mem_wdata   = cmd.clr_en ? '0 : entry_value;

    always_comb
    begin
        priority if (cmd.clr_en)
            mem_addr = clr_addr_reg;
        else if (cmd.wr_en)
            mem_addr = {wr_slot, entry_address[IDX_W-1:0]};
        else
            mem_addr = {loc_diff[SW-1:0], rd_idx};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.rd_en)
            rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_zero_reg <= !loc_in_mem;
        if (cmd.latch)
            va_reg <= virt_addr[VA_W-1:0];
    end

    assign leaf_addr = {{(XLEN - PPN_W - OFF_W){1'b0}}, entry_ppn, va_reg[OFF_W-1:0]}
                       + result_offset_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.out_status;
            if (cmd.leaf_sel)
            begin
                out_addr_reg <= leaf_addr;
                perm_reg     <= entry_seen[PERM_W-1:0];
            end
            else
            begin
                out_addr_reg <= '0;
                perm_reg     <= '0;
            end
        end
    end

    assign status    = status_reg;
    assign out_addr  = out_addr_reg;
    assign perm_bits = perm_reg;

endmodule
